>>> hw/rtl/huf_pkg.sv
// Shared widths, command and result codes, and control types of the Huffman encoder.
package huf_pkg;

  localparam int CMD_W       = 3;
  localparam int SYM_W       = 8;
  localparam int CODE_W      = 32;
  localparam int LEN_W       = 6;
  localparam int KIND_W      = 2;
  localparam int BYTE_W      = 8;
  localparam int COUNT_OUT_W = 32;
  localparam int BUF_W       = BYTE_W + CODE_W;
  localparam int TOT_W       = 6;
  localparam int PEND_W      = 3;

  localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd4;

  localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EXEC,
    ST_PACK
  } state_t;

  typedef struct packed {
    logic encode;
    logic flush;
    logic run;
    logic emit_ok;
  } pk_ctrl_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic done;
  } pk_stat_t;

endpackage

>>> hw/rtl/huf_hist.sv
// Symbol histogram: count memory with per-entry valid bits and saturating increment.
module huf_hist #(
  parameter int SYMBOLS = 256,
  parameter int COUNT_WIDTH = 32,
  localparam int AW = $clog2(SYMBOLS)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [AW-1:0]          addr,
  input  logic                   inc,
  output logic [COUNT_WIDTH-1:0] count
);

  logic [COUNT_WIDTH-1:0] mem [SYMBOLS];
  logic [SYMBOLS-1:0]     valid;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   rd_valid;
  logic [COUNT_WIDTH-1:0] inc_value;

  always_ff @(posedge clk) begin
    rd_data <= mem[addr];
    if (inc) begin
      mem[addr] <= inc_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[addr];
      if (inc) begin
        valid[addr] <= 1'b1;
      end
    end
  end

  // an entry never written reads as zero
  assign count = rd_valid ? rd_data : '0;

  // hold at the top of the range
  assign inc_value = (&count) ? count : count + COUNT_WIDTH'(1);

endmodule

>>> hw/rtl/huf_code_tab.sv
// Code table memory: masked code words and their lengths, one entry per symbol.
module huf_code_tab #(
  parameter int SYMBOLS = 256,
  localparam int AW = $clog2(SYMBOLS)
) (
  input  logic                        clk,
  input  logic [AW-1:0]               addr,
  input  logic                        we,
  input  logic [huf_pkg::CODE_W-1:0]  wr_word,
  input  logic [huf_pkg::LEN_W-1:0]   wr_len,
  output logic [huf_pkg::CODE_W-1:0]  rd_word,
  output logic [huf_pkg::LEN_W-1:0]   rd_len
);
  import huf_pkg::*;

  localparam int ENTRY_W = CODE_W + LEN_W;

  logic [ENTRY_W-1:0] mem [SYMBOLS];
  logic [ENTRY_W-1:0] rd_entry;
  logic [CODE_W-1:0]  mask;
  logic [LEN_W-1:0]   raw_len;

  // drop code bits above the length
  assign mask = (wr_len >= LEN_W'(CODE_W)) ? '1 : ((CODE_W'(1) << wr_len) - CODE_W'(1));

  always_ff @(posedge clk) begin
    rd_entry <= mem[addr];
    if (we) begin
      mem[addr] <= {wr_len, wr_word & mask};
    end
  end

  assign raw_len = rd_entry[ENTRY_W-1 -: LEN_W];
  assign rd_word = rd_entry[CODE_W-1:0];
  assign rd_len  = (raw_len > LEN_W'(CODE_W)) ? LEN_W'(CODE_W) : raw_len;

endmodule

>>> hw/rtl/huf_packer.sv
// Bit packer: merges a code into the left-aligned accumulator and drains whole bytes.
module huf_packer (
  input  logic                        clk,
  input  logic                        rst,
  input  huf_pkg::pk_ctrl_t           ctrl,
  input  logic [huf_pkg::CODE_W-1:0]  code_word,
  input  logic [huf_pkg::LEN_W-1:0]   code_length,
  output huf_pkg::pk_stat_t           stat,
  output logic [huf_pkg::BYTE_W-1:0]  out_byte
);
  import huf_pkg::*;

  logic [BYTE_W-1:0] acc;
  logic [PEND_W-1:0] pending;
  logic [BUF_W-1:0]  lbuf;
  logic [TOT_W-1:0]  total;
  logic [CODE_W-1:0] code_left;
  logic [BUF_W-1:0]  merged;

  // left-align the code; a zero-length code shifts out entirely
  assign code_left = code_word << (LEN_W'(CODE_W) - code_length);
  // place the first code bit right after the pending bits
  assign merged    = {acc, {CODE_W{1'b0}}} | ({code_left, {BYTE_W{1'b0}}} >> pending);

  assign out_byte  = lbuf[BUF_W-1 -: BYTE_W];
  assign stat.emit = ctrl.run && (total >= TOT_W'(BYTE_W)) && ctrl.emit_ok;
  assign stat.last = total < TOT_W'(2 * BYTE_W);
  assign stat.done = ctrl.run && (total < TOT_W'(BYTE_W));

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      pending <= '0;
      total   <= '0;
    end else if (ctrl.encode) begin
      total <= TOT_W'(pending) + TOT_W'(code_length);
    end else if (ctrl.flush) begin
      total <= (pending != '0) ? TOT_W'(BYTE_W) : '0;
    end else if (stat.emit) begin
      total <= total - TOT_W'(BYTE_W);
    end else if (stat.done) begin
      acc     <= lbuf[BUF_W-1 -: BYTE_W];
      pending <= total[PEND_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.encode) begin
      lbuf <= merged;
    end else if (ctrl.flush) begin
      lbuf <= {acc, {CODE_W{1'b0}}};
    end else if (stat.emit) begin
      lbuf <= lbuf << BYTE_W;
    end
  end

endmodule

>>> hw/rtl/huffman_encoder_with_histogram.sv
// Huffman encoder top level: command sequencer, memories, bit packer and result register.
//
// One command is worked at a time. A word is taken in the idle state; the next
// cycle reads the histogram and code table memories at the symbol, and the
// cycle after that executes. An encode gives up to four output bytes, which the
// packer drains one byte per cycle into the result register while that register
// is not stalled; a flush gives at most one byte. A stalled result register
// holds the sequencer while it has another word to give. The histogram is
// cleared at reset through per-entry valid bits, so no clearing pass is needed.
// Encoding a symbol whose code was never loaded gives undefined bytes.
module huffman_encoder_with_histogram #(
  parameter int SYMBOLS = 256,
  parameter int MAX_CODE_LEN = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [huf_pkg::CMD_W-1:0]        command,
  input  logic [huf_pkg::SYM_W-1:0]        symbol,
  input  logic [huf_pkg::CODE_W-1:0]       code_word,
  input  logic [huf_pkg::LEN_W-1:0]        code_length,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [huf_pkg::KIND_W-1:0]       kind,
  output logic [huf_pkg::BYTE_W-1:0]       packed_byte,
  output logic [huf_pkg::COUNT_OUT_W-1:0]  count_value,
  output logic                             last
);
  import huf_pkg::*;

  localparam int AW = $clog2(SYMBOLS);
  localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  state_t state, state_next;

  logic [CMD_W-1:0]       cmd_q;
  logic [SYM_W-1:0]       sym_q;
  logic [CODE_W-1:0]      word_q;
  logic [LEN_W-1:0]       len_q;

  logic                   accept;
  logic                   sym_ok;
  logic                   len_ok;
  logic                   reject;
  logic                   emit_ok;
  logic                   res_load;
  logic                   hist_inc;
  logic                   tab_we;
  logic [COUNT_WIDTH-1:0] hist_count;
  logic [COUNT_OUT_W-1:0] count32;
  logic [CODE_W-1:0]      tab_word;
  logic [LEN_W-1:0]       tab_len;
  logic [BYTE_W-1:0]      pk_byte;
  pk_ctrl_t               pk_ctrl;
  pk_stat_t               pk_stat;

  assign accept  = in_valid && !in_stall;
  assign sym_ok  = {1'b0, sym_q} < (SYM_W + 1)'(SYMBOLS);
  assign len_ok  = {1'b0, len_q} <= (LEN_W + 1)'(LEN_LIMIT);
  assign reject  = !sym_ok || !len_ok;
  assign emit_ok = !out_valid || !out_stall;

  if (COUNT_WIDTH > COUNT_OUT_W) begin : g_sat
    assign count32 = (|hist_count[COUNT_WIDTH-1:COUNT_OUT_W]) ? '1 :
                     hist_count[COUNT_OUT_W-1:0];
  end else begin : g_ext
    assign count32 = COUNT_OUT_W'(hist_count);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= command;
      sym_q  <= symbol;
      word_q <= code_word;
      len_q  <= code_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_next = ST_EXEC;
      ST_EXEC: begin
        unique case (cmd_q)
          CMD_READ:   state_next = emit_ok ? ST_IDLE : ST_EXEC;
          CMD_LOAD:   state_next = (reject && !emit_ok) ? ST_EXEC : ST_IDLE;
          CMD_ENCODE: state_next = sym_ok ? ST_PACK : ST_IDLE;
          CMD_FLUSH:  state_next = ST_PACK;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_PACK: begin
        if (pk_stat.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = (state != ST_IDLE);
    hist_inc        = 1'b0;
    tab_we          = 1'b0;
    res_load        = 1'b0;
    pk_ctrl.encode  = 1'b0;
    pk_ctrl.flush   = 1'b0;
    pk_ctrl.run     = (state == ST_PACK);
    pk_ctrl.emit_ok = emit_ok;
    if (state == ST_EXEC) begin
      unique case (cmd_q)
        CMD_COUNT:  hist_inc = sym_ok;
        CMD_READ:   res_load = emit_ok;
        CMD_LOAD: begin
          tab_we   = !reject;
          res_load = reject && emit_ok;
        end
        CMD_ENCODE: pk_ctrl.encode = sym_ok;
        CMD_FLUSH:  pk_ctrl.flush = 1'b1;
        default:    hist_inc = 1'b0;
      endcase
    end
  end

  huf_hist #(
    .SYMBOLS(SYMBOLS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_hist (
    .clk   (clk),
    .rst   (rst),
    .addr  (sym_q[AW-1:0]),
    .inc   (hist_inc),
    .count (hist_count)
  );

  huf_code_tab #(
    .SYMBOLS(SYMBOLS)
  ) u_code_tab (
    .clk     (clk),
    .addr    (sym_q[AW-1:0]),
    .we      (tab_we),
    .wr_word (word_q),
    .wr_len  (len_q),
    .rd_word (tab_word),
    .rd_len  (tab_len)
  );

  huf_packer u_packer (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (pk_ctrl),
    .code_word   (tab_word),
    .code_length (tab_len),
    .stat        (pk_stat),
    .out_byte    (pk_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load || pk_stat.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      kind        <= (cmd_q == CMD_READ) ? KIND_COUNT : KIND_REJECT;
      packed_byte <= '0;
      count_value <= (cmd_q == CMD_READ && sym_ok) ? count32 : '0;
      last        <= 1'b1;
    end else if (pk_stat.emit) begin
      kind        <= KIND_BYTE;
      packed_byte <= pk_byte;
      count_value <= '0;
      last        <= pk_stat.last;
    end
  end

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_BYTE |-> last)
    else $error("count or reject word without last");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    pk_stat.emit |-> emit_ok && state == ST_PACK)
    else $error("packer emitted outside pack state or into a full slot");

  a_lookup_follows_accept: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOKUP |-> $past(accept))
    else $error("memory lookup without an accepted word");

  a_no_result_in_lookup: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOKUP |-> !res_load && !pk_stat.emit)
    else $error("result loaded before memory data was ready");

endmodule
